>>> hw/rtl/fwst_pkg.sv
// shared types, sizes and the control store for the service-time queue
// used by fwst_seq and fifo_with_service_time_find_top; depends on nothing
package fwst_pkg;

  // queue geometry and stored field widths
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int TIME_BITS   = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // port field widths
  localparam int ID_W     = 16;
  localparam int TIME_W   = 16;
  localparam int TARGET_W = 24;
  localparam int OCC_W    = 5;
  localparam int SUM_W    = ((TARGET_W > TIME_BITS) ? TARGET_W : TIME_BITS) + 1;

  // action codes
  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_DEQ  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;
  localparam logic [1:0] ACT_FIND = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] tm;
  } entry_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_ACT_ENQ,
    C_ACT_DEQ,
    C_ACT_FIND,
    C_NOT_EMPTY,
    C_EMPTY,
    C_FULL,
    C_WALK_MORE,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {
    SO_KEEP,
    SO_EMPTY,
    SO_FULL
  } sop_t;

  localparam int STEP_W = 4;

  // one control word per step
  typedef struct packed {
    cond_t             cond;
    logic [STEP_W-1:0] tgt;
    logic              take;
    logic              gated;
    logic              push;
    logic              pop;
    logic              add;
    sop_t              sop;
    logic              emit;
  } cw_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic act_enq;
    logic act_deq;
    logic act_find;
    logic full;
    logic empty;
    logic walk_more;
    logic out_free;
  } flags_t;

  localparam logic [STEP_W-1:0] S_IDLE        = 4'd0;
  localparam logic [STEP_W-1:0] S_DISP_ENQ    = 4'd1;
  localparam logic [STEP_W-1:0] S_DISP_DEQ    = 4'd2;
  localparam logic [STEP_W-1:0] S_DISP_FIND   = 4'd3;
  localparam logic [STEP_W-1:0] S_PEEK        = 4'd4;
  localparam logic [STEP_W-1:0] S_SET_EMPTY   = 4'd5;
  localparam logic [STEP_W-1:0] S_ENQ         = 4'd6;
  localparam logic [STEP_W-1:0] S_PUSH        = 4'd7;
  localparam logic [STEP_W-1:0] S_ENQ_FULL    = 4'd8;
  localparam logic [STEP_W-1:0] S_DEQ         = 4'd9;
  localparam logic [STEP_W-1:0] S_POP         = 4'd10;
  localparam logic [STEP_W-1:0] S_WALK        = 4'd11;
  localparam logic [STEP_W-1:0] S_WALK_END    = 4'd12;
  localparam logic [STEP_W-1:0] S_SETTLE      = 4'd13;
  localparam logic [STEP_W-1:0] S_REPORT      = 4'd14;
  localparam logic [STEP_W-1:0] S_REPORT_WAIT = 4'd15;

  // control store: a taken jump goes to tgt, otherwise to the next step
  function automatic cw_t ucode(input logic [STEP_W-1:0] step);
    cw_t w;
    w = '0;
    case (step)
      S_IDLE: begin
        w.take = 1'b1;
        w.cond = C_NO_IN;
        w.tgt  = S_IDLE;
      end
      S_DISP_ENQ: begin
        w.cond = C_ACT_ENQ;
        w.tgt  = S_ENQ;
      end
      S_DISP_DEQ: begin
        w.cond = C_ACT_DEQ;
        w.tgt  = S_DEQ;
      end
      S_DISP_FIND: begin
        w.cond = C_ACT_FIND;
        w.tgt  = S_WALK;
      end
      S_PEEK: begin
        w.cond = C_NOT_EMPTY;
        w.tgt  = S_REPORT;
      end
      S_SET_EMPTY: begin
        w.sop  = SO_EMPTY;
        w.cond = C_ALWAYS;
        w.tgt  = S_REPORT;
      end
      S_ENQ: begin
        w.cond = C_FULL;
        w.tgt  = S_ENQ_FULL;
      end
      S_PUSH: begin
        w.push = 1'b1;
        w.cond = C_ALWAYS;
        w.tgt  = S_SETTLE;
      end
      S_ENQ_FULL: begin
        w.sop  = SO_FULL;
        w.cond = C_ALWAYS;
        w.tgt  = S_REPORT;
      end
      S_DEQ: begin
        w.cond = C_EMPTY;
        w.tgt  = S_SET_EMPTY;
      end
      S_POP: begin
        w.pop  = 1'b1;
        w.cond = C_ALWAYS;
        w.tgt  = S_REPORT;
      end
      S_WALK: begin
        // remove one head entry per cycle while the sum stays below target
        w.gated = 1'b1;
        w.pop   = 1'b1;
        w.add   = 1'b1;
        w.cond  = C_WALK_MORE;
        w.tgt   = S_WALK;
      end
      S_WALK_END: begin
        w.cond = C_EMPTY;
        w.tgt  = S_SET_EMPTY;
      end
      S_SETTLE: begin
        w.cond = C_NEVER;
        w.tgt  = S_REPORT;
      end
      S_REPORT: begin
        w.gated = 1'b1;
        w.emit  = 1'b1;
        w.cond  = C_OUT_FREE;
        w.tgt   = S_IDLE;
      end
      S_REPORT_WAIT: begin
        w.cond = C_ALWAYS;
        w.tgt  = S_REPORT;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.tgt  = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/fwst_seq.sv
// microprogram sequencer: step counter, control store lookup and jump test
// depends on fwst_pkg for the control word, flags and the program
module fwst_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  fwst_pkg::flags_t flags,
  output fwst_pkg::cw_t    cw,
  output logic             taken
);

  logic [fwst_pkg::STEP_W-1:0] step_r;
  logic [fwst_pkg::STEP_W-1:0] step_nxt;

  assign cw = fwst_pkg::ucode(step_r);

  always_comb begin
    unique case (cw.cond)
      fwst_pkg::C_NEVER:     taken = 1'b0;
      fwst_pkg::C_ALWAYS:    taken = 1'b1;
      fwst_pkg::C_NO_IN:     taken = !flags.in_valid;
      fwst_pkg::C_ACT_ENQ:   taken = flags.act_enq;
      fwst_pkg::C_ACT_DEQ:   taken = flags.act_deq;
      fwst_pkg::C_ACT_FIND:  taken = flags.act_find;
      fwst_pkg::C_NOT_EMPTY: taken = !flags.empty;
      fwst_pkg::C_EMPTY:     taken = flags.empty;
      fwst_pkg::C_FULL:      taken = flags.full;
      fwst_pkg::C_WALK_MORE: taken = flags.walk_more;
      fwst_pkg::C_OUT_FREE:  taken = flags.out_free;
      default:               taken = 1'b0;
    endcase
  end

  assign step_nxt = taken ? cw.tgt : step_r + fwst_pkg::STEP_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= fwst_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> hw/rtl/fifo_with_service_time_find_top.sv
// Bounded queue of (id, service time) entries in a 16-slot ring buffer with
// enqueue, dequeue, peek and find-by-target-time actions. One item is handled
// at a time by a microcoded sequencer; a result sits in an output register so
// the next item can be taken while it waits. Find removes one head entry per
// cycle, while the summed service time stays below the target, through the
// single read port of the entry memory. No clearing pass is needed after
// reset.
// depends on fwst_pkg and fwst_seq
module fifo_with_service_time_find_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // entry_id[15:0], service_time[31:16], target_time[55:32]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // head_id[15:0], head_time[31:16], is_empty[32],
                                  // occupancy[37:33], zero fill[39:38]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int PTR_W = fwst_pkg::PTR_W;
  localparam int CNT_W = fwst_pkg::CNT_W;
  localparam int SUM_W = fwst_pkg::SUM_W;

  fwst_pkg::cw_t    cw;
  fwst_pkg::flags_t flags;
  logic             taken;

  // item registers
  logic [1:0]                     act_r;
  logic [fwst_pkg::ID_BITS-1:0]   id_r;
  logic [fwst_pkg::TIME_BITS-1:0] tm_r;
  logic [fwst_pkg::TARGET_W-1:0]  tgt_r;
  logic [1:0]                     status_r;
  logic [SUM_W-1:0]               sum_r;

  // queue state
  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  head_nxt;
  logic [PTR_W-1:0]  tail_r;
  logic [CNT_W-1:0]  count_r;
  fwst_pkg::entry_t  mem [fwst_pkg::QUEUE_DEPTH];
  fwst_pkg::entry_t  rd_r;

  // result register
  logic                      out_valid_r;
  logic [1:0]                out_status_r;
  logic [fwst_pkg::ID_W-1:0]   out_id_r;
  logic [fwst_pkg::TIME_W-1:0] out_tm_r;
  logic                      out_empty_r;
  logic [fwst_pkg::OCC_W-1:0]  out_occ_r;

  logic             accept;
  logic             op_en;
  logic             push_en;
  logic             pop_en;
  logic             add_en;
  logic             emit_en;
  logic             q_empty;
  logic [SUM_W-1:0] sum_add;
  logic [PTR_W:0]   ring_sum;
  logic [PTR_W:0]   tail_chk;

  fwst_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .cw    (cw),
    .taken (taken)
  );

  assign in_tready = cw.take;
  assign accept    = in_tvalid && in_tready;

  // gated words act only when their jump is taken
  assign op_en   = !cw.gated || taken;
  assign push_en = cw.push && op_en;
  assign pop_en  = cw.pop && op_en;
  assign add_en  = cw.add && op_en;
  assign emit_en = cw.emit && op_en;

  assign q_empty = (count_r == '0);
  assign sum_add = sum_r + SUM_W'(rd_r.tm);

  always_comb begin
    flags.in_valid  = in_tvalid;
    flags.act_enq   = (act_r == fwst_pkg::ACT_ENQ);
    flags.act_deq   = (act_r == fwst_pkg::ACT_DEQ);
    flags.act_find  = (act_r == fwst_pkg::ACT_FIND);
    flags.full      = (count_r == CNT_W'(fwst_pkg::QUEUE_DEPTH));
    flags.empty     = q_empty;
    flags.walk_more = !q_empty && (sum_add < SUM_W'(tgt_r));
    flags.out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    head_nxt = head_r;
    if (pop_en) begin
      head_nxt = (head_r == PTR_W'(fwst_pkg::QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      if (push_en) begin
        tail_r  <= (tail_r == PTR_W'(fwst_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
        count_r <= count_r + CNT_W'(1);
      end else if (pop_en) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (emit_en) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_tuser;
      id_r     <= fwst_pkg::ID_BITS'(in_tdata[15:0]);
      tm_r     <= fwst_pkg::TIME_BITS'(in_tdata[31:16]);
      tgt_r    <= in_tdata[55:32];
      status_r <= fwst_pkg::ST_OK;
      sum_r    <= '0;
    end else begin
      if (add_en) begin
        sum_r <= sum_add;
      end
      case (cw.sop)
        fwst_pkg::SO_EMPTY: status_r <= fwst_pkg::ST_EMPTY;
        fwst_pkg::SO_FULL:  status_r <= fwst_pkg::ST_FULL;
        default:            status_r <= status_r;
      endcase
    end
    if (emit_en) begin
      out_status_r <= status_r;
      out_id_r     <= q_empty ? '0 : fwst_pkg::ID_W'(rd_r.id);
      out_tm_r     <= q_empty ? '0 : fwst_pkg::TIME_W'(rd_r.tm);
      out_empty_r  <= q_empty;
      out_occ_r    <= fwst_pkg::OCC_W'(count_r);
    end
  end

  // entry memory: one write port at the tail, registered read of the next head
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[tail_r] <= '{id: id_r, tm: tm_r};
    end
    rd_r <= mem[head_nxt];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_occ_r, out_empty_r, out_tm_r, out_id_r};

  // ring position the tail must hold given head and count
  assign ring_sum = {1'b0, head_r} + (PTR_W + 1)'(count_r);
  assign tail_chk = (ring_sum >= (PTR_W + 1)'(fwst_pkg::QUEUE_DEPTH)) ?
                    ring_sum - (PTR_W + 1)'(fwst_pkg::QUEUE_DEPTH) : ring_sum;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(fwst_pkg::QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r == PTR_W'(tail_chk))
    else $error("tail pointer disagrees with head and count");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("second item taken while one is in work");

  a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not lower the count by one");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_en |-> !flags.full)
    else $error("push into a full queue");

endmodule
